@@ hw/rtl/pps_pkg.sv @@
// Shared types, constants and tables for the pure pursuit steering block.
package pps_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int VEC_W   = COORD_W + 4;
  localparam int ANG_W   = 34;
  localparam int MUL_W   = VEC_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = PROD_W + 24;
  localparam int Q_W     = 33;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W  = 5;
  localparam int DIV_K_W = 6;
  localparam int DIV_TOP = 32;
  localparam int DSH_W   = PROD_W + DIV_TOP;

  localparam logic [27:0] GAIN_Q28 = 28'd163008218;
  localparam logic [31:0] EPS_Q32  = 32'd4294967;

  localparam logic [1:0] CMD_POSE   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] REG_SPEED     = 2'd0;
  localparam logic [1:0] REG_LOOKAHEAD = 2'd1;
  localparam logic [1:0] REG_MAX_TURN  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PT_A, ST_PT_B, ST_PT_C, ST_PT_D,
    ST_ROT, ST_UNX, ST_UNY, ST_UNL, ST_SQ2, ST_NUM, ST_DIVS, ST_DIV, ST_EMIT
  } state_t;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/pps_in_if.sv @@
// Input channel carrying pose, path point and end items.
interface pps_in_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [15:0]        heading;
  modport source (output valid, cmd, coord_x, coord_y, heading, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, heading, output ready);
endinterface

@@ hw/rtl/pps_out_if.sv @@
// Output channel carrying steering commands.
interface pps_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] linear_cmd;
  logic [31:0] angular_cmd;
  modport source (output valid, ok, linear_cmd, angular_cmd, input ready);
  modport sink   (input valid, ok, linear_cmd, angular_cmd, output ready);
endinterface

@@ hw/rtl/pps_cfg_if.sv @@
// Configuration write channel.
interface pps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/pps_cordic.sv @@
// Iterative CORDIC rotator, one micro-rotation per cycle.
module pps_cordic import pps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] x0,
  input  logic signed [VEC_W-1:0] y0,
  input  logic signed [ANG_W-1:0] z0,
  output logic                    done,
  output logic signed [VEC_W-1:0] xr,
  output logic signed [VEC_W-1:0] yr
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic signed [ANG_W-1:0] z;
  logic signed [VEC_W-1:0] sx, sy;
  logic signed [ANG_W-1:0] at;

  always_comb begin
    sx = xr >>> step;
    sy = yr >>> step;
    at = $signed({2'b00, atan_turn(step)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x0;
      yr <= y0;
      z  <= z0;
    end else if (busy) begin
      if (z >= 0) begin
        xr <= xr - sy;
        yr <= yr + sx;
        z  <= z - at;
      end else begin
        xr <= xr + sy;
        yr <= yr - sx;
        z  <= z + at;
      end
    end
  end

endmodule

@@ hw/rtl/pps_divider.sv @@
// Restoring divider producing one quotient bit per cycle.
module pps_divider import pps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [PROD_W-1:0] den,
  output logic              done,
  output logic [Q_W-1:0]    quo
);

  logic               busy;
  logic [DIV_K_W-1:0] k;
  logic [NUM_W-1:0]   rem;
  logic [DSH_W-1:0]   dsh;
  logic               fits;

  assign fits = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= DIV_K_W'(DIV_TOP);
      end else if (busy) begin
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        k <= k - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {DIV_TOP{1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (fits) rem <= rem - NUM_W'(dsh);
      quo <= {quo[Q_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

endmodule

@@ hw/rtl/pure_pursuit_steering_top.sv @@
// Pure pursuit steering: sequencer, shared multiplier, CORDIC and divider.
// Pose items end with the transfer; path point squares share one multiplier.
// End items run the 20 CORDIC rotations, gain removal, the squares, the numerator and the 33-bit
// divider, then load the output register; if lx <= 0 they skip from gain removal to the output.
// Empty-path end items go straight to the output. One item is in work at a time.
// Synchronous active-high reset clears pose, target, flags, configuration and output valid.
module pure_pursuit_steering_top import pps_pkg::*; (
  input logic clk,
  input logic rst,
  pps_in_if.sink   in_ch,
  pps_out_if.source out_ch,
  pps_cfg_if.sink  cfg_ch
);

  // Configuration registers; writes are always taken.
  logic signed [31:0] linear_speed;
  logic [30:0]        lookahead_distance;
  logic [30:0]        max_turn_rate;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_speed       <= 32'sd13107;
      lookahead_distance <= 31'd26214;
      max_turn_rate      <= 31'd65536;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SPEED:     linear_speed       <= $signed(cfg_ch.data);
        REG_LOOKAHEAD: lookahead_distance <= cfg_ch.data[30:0];
        REG_MAX_TURN:  max_turn_rate      <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  // Tracking state.
  logic signed [COORD_W-1:0] robot_x, robot_y, target_x, target_y;
  logic [15:0]               robot_heading;
  logic                      target_locked, any_point_seen;

  state_t state, state_next;
  logic   in_xfer;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;

  // Offsets of the incoming point from the robot, and their magnitudes.
  logic signed [DIFF_W-1:0] pdx, pdy;
  logic [DIFF_W-1:0]        pax, pay;
  logic [DIFF_W-1:0]        ax, ay;
  always_comb begin
    pdx = DIFF_W'($signed(in_ch.coord_x)) - DIFF_W'(robot_x);
    pdy = DIFF_W'($signed(in_ch.coord_y)) - DIFF_W'(robot_y);
    pax = pdx[DIFF_W-1] ? DIFF_W'(-pdx) : DIFF_W'(pdx);
    pay = pdy[DIFF_W-1] ? DIFF_W'(-pdy) : DIFF_W'(pdy);
  end

  // Target offset and the quadrant fold of minus the heading.
  logic signed [VEC_W-1:0] tdx, tdy, rx0, ry0;
  logic signed [31:0]      zraw;
  logic signed [ANG_W-1:0] zs, rz0;
  always_comb begin
    tdx  = VEC_W'(target_x) - VEC_W'(robot_x);
    tdy  = VEC_W'(target_y) - VEC_W'(robot_y);
    zraw = $signed(32'h0 - {robot_heading, 16'h0});
    zs   = ANG_W'(zraw);
    rx0  = tdx;
    ry0  = tdy;
    rz0  = zs;
    if (zs > $signed(ANG_W'(34'sh40000000))) begin
      rx0 = -tdx;
      ry0 = -tdy;
      rz0 = zs - $signed(ANG_W'(34'sh80000000));
    end else if (zs < -$signed(ANG_W'(34'sh40000000))) begin
      rx0 = -tdx;
      ry0 = -tdy;
      rz0 = zs + $signed(ANG_W'(34'sh80000000));
    end
  end

  // Shared multiplier with a registered product.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_q;
  always_ff @(posedge clk) mul_q <= mul_a * mul_b;

  logic                    rot_start, rot_done;
  logic signed [VEC_W-1:0] rot_x, rot_y;
  logic                    div_start, div_done;
  logic [Q_W-1:0]          div_q;
  logic [NUM_W-1:0]        num;
  logic [PROD_W-1:0]       den, acc;
  logic signed [VEC_W-1:0] lx, ly;
  logic [MUL_W-1:0]        mag_lx, mag_ly, mag_rx, mag_ry, mag_speed;
  logic signed [VEC_W-1:0] unscaled;
  logic [Q_W-1:0]          angmag;
  logic [31:0]             ang_signed;

  // Result registers waiting for the output register.
  logic        res_ok;
  logic [31:0] res_lin, res_ang;
  logic        out_valid;

  pps_cordic u_cordic (
    .clk(clk), .rst(rst), .start(rot_start),
    .x0(rx0), .y0(ry0), .z0(rz0),
    .done(rot_done), .xr(rot_x), .yr(rot_y)
  );

  pps_divider u_divider (
    .clk(clk), .rst(rst), .start(div_start),
    .num(num), .den(den), .done(div_done), .quo(div_q)
  );

  // Divider operands: the speed times ly product arrives as the divider starts,
  // while acc already holds lx^2 + ly^2.
  always_comb begin
    num = NUM_W'(mul_q) << 17;
    den = (acc < PROD_W'(EPS_Q32)) ? PROD_W'(EPS_Q32) : acc;
  end

  always_comb begin
    mag_lx    = lx[VEC_W-1] ? MUL_W'(-lx) : MUL_W'(lx);
    mag_ly    = ly[VEC_W-1] ? MUL_W'(-ly) : MUL_W'(ly);
    mag_rx    = rot_x[VEC_W-1] ? MUL_W'(-rot_x) : MUL_W'(rot_x);
    mag_ry    = rot_y[VEC_W-1] ? MUL_W'(-rot_y) : MUL_W'(rot_y);
    mag_speed = linear_speed[31] ? MUL_W'(-$signed({linear_speed[31], linear_speed}))
                                 : MUL_W'(linear_speed);
    unscaled  = $signed(mul_q[28 +: VEC_W]);
    angmag    = (div_q > Q_W'(max_turn_rate)) ? Q_W'(max_turn_rate) : div_q;
    ang_signed = (linear_speed[31] != ly[VEC_W-1]) ? 32'(-angmag) : angmag[31:0];
  end

  // Sequencer: next state and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    rot_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.cmd == CMD_POINT && !target_locked) state_next = ST_PT_A;
          else if (in_ch.cmd == CMD_END) begin
            if (any_point_seen) begin
              state_next = ST_ROT;
              rot_start  = 1'b1;
            end else state_next = ST_EMIT;
          end
        end
      end
      ST_PT_A: begin
        mul_a = MUL_W'(ax);
        mul_b = MUL_W'(ax);
        if (ax >= DIFF_W'(lookahead_distance) || ay >= DIFF_W'(lookahead_distance))
          state_next = ST_IDLE;
        else state_next = ST_PT_B;
      end
      ST_PT_B: begin
        mul_a = MUL_W'(ay);
        mul_b = MUL_W'(ay);
        state_next = ST_PT_C;
      end
      ST_PT_C: begin
        mul_a = MUL_W'(lookahead_distance);
        mul_b = MUL_W'(lookahead_distance);
        state_next = ST_PT_D;
      end
      ST_PT_D: state_next = ST_IDLE;
      ST_ROT: begin
        if (rot_done) state_next = ST_UNX;
      end
      ST_UNX: begin
        mul_a = mag_rx;
        mul_b = MUL_W'(GAIN_Q28);
        state_next = ST_UNY;
      end
      ST_UNY: begin
        mul_a = mag_ry;
        mul_b = MUL_W'(GAIN_Q28);
        state_next = ST_UNL;
      end
      ST_UNL: begin
        if (lx <= 0) state_next = ST_EMIT;
        else begin
          mul_a = mag_lx;
          mul_b = mag_lx;
          state_next = ST_SQ2;
        end
      end
      ST_SQ2: begin
        mul_a = mag_ly;
        mul_b = mag_ly;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        mul_a = mag_speed;
        mul_b = mag_ly;
        state_next = ST_DIVS;
      end
      ST_DIVS: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_DIVS) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Control state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x        <= '0;
      robot_y        <= '0;
      robot_heading  <= '0;
      target_x       <= '0;
      target_y       <= '0;
      target_locked  <= 1'b0;
      any_point_seen <= 1'b0;
    end else begin
      if (in_xfer && in_ch.cmd == CMD_POSE) begin
        robot_x        <= $signed(in_ch.coord_x);
        robot_y        <= $signed(in_ch.coord_y);
        robot_heading  <= in_ch.heading;
        target_x       <= '0;
        target_y       <= '0;
        target_locked  <= 1'b0;
        any_point_seen <= 1'b0;
      end else if (in_xfer && in_ch.cmd == CMD_POINT && !target_locked) begin
        target_x       <= $signed(in_ch.coord_x);
        target_y       <= $signed(in_ch.coord_y);
        any_point_seen <= 1'b1;
      end
      if (state == ST_PT_A &&
          (ax >= DIFF_W'(lookahead_distance) || ay >= DIFF_W'(lookahead_distance)))
        target_locked <= 1'b1;
      if (state == ST_PT_D && acc >= mul_q) target_locked <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax <= pax;
      ay <= pay;
    end
    unique case (state)
      ST_PT_B: acc <= mul_q;
      ST_PT_C: acc <= acc + mul_q;
      ST_UNY:  lx  <= rot_x[VEC_W-1] ? -unscaled : unscaled;
      ST_UNL:  ly  <= rot_y[VEC_W-1] ? -unscaled : unscaled;
      ST_SQ2:  acc <= mul_q;
      ST_NUM:  acc <= acc + mul_q;
      default: ;
    endcase
  end

  // Result selection and the output register.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer && in_ch.cmd == CMD_END && !any_point_seen) begin
      res_ok  <= 1'b0;
      res_lin <= '0;
      res_ang <= '0;
    end else if (state == ST_UNL && lx <= 0) begin
      res_ok  <= 1'b1;
      res_lin <= '0;
      res_ang <= 32'(max_turn_rate);
    end else if (state == ST_DIV && div_done) begin
      res_ok  <= 1'b1;
      res_lin <= linear_speed;
      res_ang <= ang_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_EMIT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || out_ch.ready)) begin
      out_ch.ok          <= res_ok;
      out_ch.linear_cmd  <= res_lin;
      out_ch.angular_cmd <= res_ang;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
